[design/bcap_pkg.sv]
`timescale 1ns / 1ps
package bcap_pkg;

   // defaults for top-level parameters
   localparam int NUMBER_BITS_DEF = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   // command codes
   localparam logic [7:0] CODE_FILE = 8'd3;
   localparam logic [7:0] CODE_GOT  = 8'd6;
   localparam logic [7:0] CODE_GET  = 8'd9;
   localparam logic [7:0] CODE_SKIP = 8'd10;

   // characters
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_BSL   = 8'h5c;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_D0    = 8'h30;
   localparam logic [7:0] CHAR_D9    = 8'h39;

   typedef enum logic [2:0] {
      PH_CMD, PH_NAME, PH_NUM1, PH_NUM2, PH_NUM3, PH_DRAIN, PH_OTHER
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK, ST_MALFORMED, ST_NOT_PARSED
   } status_type;

   // everything one input byte produces: up to four name bytes and a report
   typedef struct packed {
      logic [3:0][7:0] names;
      logic [2:0]      name_cnt;
      logic            report;
      status_type      status;
      logic [7:0]      cmd;
      logic [31:0]     num0;
      logic [31:0]     num1;
      logic [31:0]     num2;
   } bundle_type;

   // hex digit decode: bit 4 = valid, bits 3:0 = value
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
         r = {1'b1, c[3:0] + 4'd9};
      return r;
   endfunction

endpackage

[design/binkp_command_arg_parser_unit.sv]
`timescale 1ns / 1ps
// Command frame argument parser. Takes one frame byte per cycle (first byte is the
// command code) and emits unescaped filename bytes, then one report item with the
// status and the decoded numbers on the frame's last byte. A byte is accepted every
// cycle while the bundle queue between the byte parser and the output sequencer has
// room; each byte yields zero to four result items, which the output side sends at
// one per cycle, so the sustained input rate is one byte per cycle as long as the
// escape flush bursts average out and the receiver does not stall. A byte's result
// items are registered in the bundle queue and then in the output register.
module binkp_command_arg_parser_unit #(
   parameter int NUMBER_BITS = bcap_pkg::NUMBER_BITS_DEF,
   parameter int QUEUE_DEPTH = bcap_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_name_byte,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_command_code,
   output logic [31:0] rsp_first_number,
   output logic [31:0] rsp_time_stamp,
   output logic [31:0] rsp_file_offset,
   output logic        rsp_out_last
);

   logic accept, push, pop, q_valid, q_full;
   bcap_pkg::bundle_type bundle, head;

   assign req_stall = q_full;
   assign accept = req_valid && !q_full;

   bcap_front #(.NUMBER_BITS(NUMBER_BITS)) u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .in_byte(req_in_byte), .in_last(req_in_last),
      .push(push), .bundle(bundle)
   );

   bcap_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(bundle),
      .pop(pop), .q_valid(q_valid), .q_full(q_full), .head(head)
   );

   bcap_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_kind(rsp_out_kind), .rsp_name_byte(rsp_name_byte),
      .rsp_status(rsp_status), .rsp_command_code(rsp_command_code),
      .rsp_first_number(rsp_first_number), .rsp_time_stamp(rsp_time_stamp),
      .rsp_file_offset(rsp_file_offset), .rsp_out_last(rsp_out_last)
   );

   // queue is never read empty or written full
   a_pop_valid: assert property (@(posedge clock) disable iff (reset) pop |-> q_valid)
      else $error("pop from empty queue");
   a_push_room: assert property (@(posedge clock) disable iff (reset) push |-> !q_full)
      else $error("push into full queue");
   // no output item right after reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("output valid after reset");
   // a report carries the last flag and no name byte
   a_report_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |-> rsp_out_kind && rsp_name_byte == 8'd0)
      else $error("malformed report item");

endmodule

[design/bcap_front.sv]
`timescale 1ns / 1ps
module bcap_front #(
   parameter int NUMBER_BITS = bcap_pkg::NUMBER_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output logic                 push,
   output bcap_pkg::bundle_type bundle
);

   bcap_pkg::phase_type   phase_ff, phase_in;
   logic [7:0]            cmd_ff, cmd_in;
   logic [2:0][7:0]       hold_ff, hold_in;
   logic [1:0]            hcnt_ff, hcnt_in;
   logic [NUMBER_BITS-1:0] acc0_ff, acc0_in, acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic                  dig_ff, dig_in;
   logic                  err_ff, err_in;

   logic [3:0][7:0] bf;
   logic [2:0]      n;
   logic            stop;
   logic            bad;
   logic [3:0][7:0] esc_names;
   logic [2:0]      esc_cnt;
   logic [4:0]      h2, h3;
   logic            is_file;
   logic            isdig;
   bcap_pkg::status_type st;

   // saturating acc*10 + digit
   function automatic logic [NUMBER_BITS-1:0] sat_acc(input logic [NUMBER_BITS-1:0] a,
                                                       input logic [7:0] c);
      logic [NUMBER_BITS+3:0] t;
      t = ({4'd0, a} << 3) + ({4'd0, a} << 1) + (NUMBER_BITS + 4)'(c[3:0]);
      if (t[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) return '1;
      return t[NUMBER_BITS-1:0];
   endfunction

   assign isdig = in_byte >= bcap_pkg::CHAR_D0 && in_byte <= bcap_pkg::CHAR_D9;

   // escape scan over held bytes plus the new one
   always_comb begin
      bf = {8'd0, hold_ff};
      n = {1'b0, hcnt_ff};
      bf[hcnt_ff] = in_byte;
      n = n + 3'd1;
      stop = 1'b0;
      bad = 1'b0;
      h2 = 5'd0;
      h3 = 5'd0;
      esc_names = '0;
      esc_cnt = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (!stop && n != 3'd0) begin
            h2 = bcap_pkg::hex_val(bf[2]);
            h3 = bcap_pkg::hex_val(bf[3]);
            bad = (bf[0] != bcap_pkg::CHAR_BSL) ||
                  (n >= 3'd2 && bf[1] != bcap_pkg::CHAR_X) ||
                  (n >= 3'd3 && !h2[4]) || (n >= 3'd4 && !h3[4]);
            if (bad) begin
               esc_names[esc_cnt[1:0]] = bf[0];
               esc_cnt = esc_cnt + 3'd1;
               bf = bf >> 8;
               n = n - 3'd1;
            end else if (n == 3'd4) begin
               esc_names[esc_cnt[1:0]] = {h2[3:0], h3[3:0]};
               esc_cnt = esc_cnt + 3'd1;
               n = 3'd0;
            end else begin
               stop = 1'b1;
            end
         end
      end
   end

   // byte handling per phase, then the report on the last byte
   always_comb begin
      phase_in = phase_ff;
      cmd_in = cmd_ff;
      hold_in = hold_ff;
      hcnt_in = hcnt_ff;
      acc0_in = acc0_ff;
      acc1_in = acc1_ff;
      acc2_in = acc2_ff;
      dig_in = dig_ff;
      err_in = err_ff;
      is_file = cmd_ff == bcap_pkg::CODE_FILE;
      bundle = '0;
      st = bcap_pkg::ST_OK;
      case (phase_ff)
         bcap_pkg::PH_CMD: begin
            cmd_in = in_byte;
            is_file = in_byte == bcap_pkg::CODE_FILE;
            if (in_byte == bcap_pkg::CODE_FILE || in_byte == bcap_pkg::CODE_GOT ||
                in_byte == bcap_pkg::CODE_GET || in_byte == bcap_pkg::CODE_SKIP)
               phase_in = bcap_pkg::PH_NAME;
            else
               phase_in = bcap_pkg::PH_OTHER;
         end
         bcap_pkg::PH_NAME: begin
            if (in_byte == bcap_pkg::CHAR_SPACE) begin
               bundle.names = {8'd0, hold_ff};
               bundle.name_cnt = {1'b0, hcnt_ff};
               hcnt_in = 2'd0;
               dig_in = 1'b0;
               phase_in = bcap_pkg::PH_NUM1;
            end else if (in_byte == bcap_pkg::CHAR_NUL) begin
               hcnt_in = 2'd0;
               err_in = 1'b1;
               phase_in = bcap_pkg::PH_DRAIN;
            end else if (in_last) begin
               hcnt_in = 2'd0;
            end else begin
               bundle.names = esc_names;
               bundle.name_cnt = esc_cnt;
               hold_in = bf[2:0];
               hcnt_in = n[1:0];
            end
         end
         bcap_pkg::PH_NUM1: begin
            if (isdig) begin
               acc0_in = sat_acc(acc0_ff, in_byte);
               dig_in = 1'b1;
            end else if (is_file) begin
               if (in_byte == bcap_pkg::CHAR_SPACE && dig_ff) begin
                  dig_in = 1'b0;
                  phase_in = bcap_pkg::PH_NUM2;
               end else begin
                  err_in = 1'b1;
                  phase_in = bcap_pkg::PH_DRAIN;
               end
            end else begin
               phase_in = bcap_pkg::PH_DRAIN;
            end
         end
         bcap_pkg::PH_NUM2: begin
            if (isdig) acc1_in = sat_acc(acc1_ff, in_byte);
            else if (in_byte == bcap_pkg::CHAR_SPACE) phase_in = bcap_pkg::PH_NUM3;
            else if (in_byte == bcap_pkg::CHAR_NUL) phase_in = bcap_pkg::PH_DRAIN;
            else begin
               err_in = 1'b1;
               phase_in = bcap_pkg::PH_DRAIN;
            end
         end
         bcap_pkg::PH_NUM3: begin
            if (isdig) acc2_in = sat_acc(acc2_ff, in_byte);
            else phase_in = bcap_pkg::PH_DRAIN;
         end
         default: ;
      endcase
      bundle.cmd = cmd_in;
      if (in_last) begin
         if (phase_in == bcap_pkg::PH_OTHER) st = bcap_pkg::ST_NOT_PARSED;
         else if (phase_in == bcap_pkg::PH_NAME || err_in) st = bcap_pkg::ST_MALFORMED;
         else if (phase_in == bcap_pkg::PH_NUM1 && is_file) st = bcap_pkg::ST_MALFORMED;
         bundle.report = 1'b1;
         bundle.status = st;
         if (st == bcap_pkg::ST_OK) begin
            bundle.num0 = 32'(acc0_in);
            if (is_file) begin
               bundle.num1 = 32'(acc1_in);
               bundle.num2 = 32'(acc2_in);
            end
         end
         // back to the idle state for the next frame
         phase_in = bcap_pkg::PH_CMD;
         cmd_in = 8'd0;
         hcnt_in = 2'd0;
         acc0_in = '0;
         acc1_in = '0;
         acc2_in = '0;
         dig_in = 1'b0;
         err_in = 1'b0;
      end
   end

   assign push = accept && (bundle.name_cnt != 3'd0 || bundle.report);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bcap_pkg::PH_CMD;
         cmd_ff <= 8'd0;
         hcnt_ff <= 2'd0;
         acc0_ff <= '0;
         acc1_ff <= '0;
         acc2_ff <= '0;
         dig_ff <= 1'b0;
         err_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cmd_ff <= cmd_in;
         hcnt_ff <= hcnt_in;
         acc0_ff <= acc0_in;
         acc1_ff <= acc1_in;
         acc2_ff <= acc2_in;
         dig_ff <= dig_in;
         err_ff <= err_in;
      end
   end

   // escape bytes: no reset, only read under the hold count
   always_ff @(posedge clock) begin
      if (accept) hold_ff <= hold_in;
   end

endmodule

[design/bcap_queue.sv]
`timescale 1ns / 1ps
module bcap_queue #(
   parameter int QUEUE_DEPTH = bcap_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bcap_pkg::bundle_type push_data,
   input  logic                 pop,
   output logic                 q_valid,
   output logic                 q_full,
   output bcap_pkg::bundle_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   bcap_pkg::bundle_type mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign q_valid = cnt_ff != CW'(0);
   assign q_full = cnt_ff == CW'(QUEUE_DEPTH);
   assign head = mem_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : wr_ff + PW'(1);
      if (pop) rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : rd_ff + PW'(1);
      if (push && !pop) cnt_in = cnt_ff + CW'(1);
      else if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

[design/bcap_back.sv]
`timescale 1ns / 1ps
module bcap_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  bcap_pkg::bundle_type head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_out_kind,
   output logic [7:0]           rsp_name_byte,
   output logic [1:0]           rsp_status,
   output logic [7:0]           rsp_command_code,
   output logic [31:0]          rsp_first_number,
   output logic [31:0]          rsp_time_stamp,
   output logic [31:0]          rsp_file_offset,
   output logic                 rsp_out_last
);

   logic [2:0] idx_ff, idx_in;
   logic [2:0] items;
   logic       load;
   logic       is_name;
   logic       valid_ff, valid_in;
   logic       kind_ff, kind_in, last_ff, last_in;
   logic [7:0] byte_ff, byte_in, cmd_ff, cmd_in;
   logic [1:0] st_ff, st_in;
   logic [31:0] n0_ff, n0_in, n1_ff, n1_in, n2_ff, n2_in;

   assign items = head.name_cnt + {2'd0, head.report};
   assign load = q_valid && (!valid_ff || !rsp_stall);
   assign pop = load && (idx_ff + 3'd1 == items);
   assign is_name = idx_ff < head.name_cnt;

   // pick the next item of the head bundle
   always_comb begin
      idx_in = idx_ff;
      if (pop) idx_in = 3'd0;
      else if (load) idx_in = idx_ff + 3'd1;
      valid_in = valid_ff && rsp_stall;
      kind_in = kind_ff;
      last_in = last_ff;
      byte_in = byte_ff;
      cmd_in = cmd_ff;
      st_in = st_ff;
      n0_in = n0_ff;
      n1_in = n1_ff;
      n2_in = n2_ff;
      if (load) begin
         valid_in = 1'b1;
         cmd_in = head.cmd;
         kind_in = !is_name;
         last_in = !is_name;
         byte_in = is_name ? head.names[idx_ff[1:0]] : 8'd0;
         st_in = is_name ? 2'(bcap_pkg::ST_OK) : 2'(head.status);
         n0_in = is_name ? 32'd0 : head.num0;
         n1_in = is_name ? 32'd0 : head.num1;
         n2_in = is_name ? 32'd0 : head.num2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      last_ff <= last_in;
      byte_ff <= byte_in;
      cmd_ff <= cmd_in;
      st_ff <= st_in;
      n0_ff <= n0_in;
      n1_ff <= n1_in;
      n2_ff <= n2_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_name_byte = byte_ff;
   assign rsp_status = st_ff;
   assign rsp_command_code = cmd_ff;
   assign rsp_first_number = n0_ff;
   assign rsp_time_stamp = n1_ff;
   assign rsp_file_offset = n2_ff;
   assign rsp_out_last = last_ff;

endmodule

[dv/binkp_command_arg_parser_unit_test.sv]
`timescale 1ns / 1ps
module binkp_command_arg_parser_unit_test;

   typedef struct {
      logic        kind;
      logic [7:0]  name_byte;
      logic [1:0]  status;
      logic [7:0]  cmd;
      logic [31:0] num0;
      logic [31:0] num1;
      logic [31:0] num2;
      logic        last;
   } parse_item_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_in_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_out_kind;
   logic [7:0]  rsp_name_byte;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_command_code;
   logic [31:0] rsp_first_number;
   logic [31:0] rsp_time_stamp;
   logic [31:0] rsp_file_offset;
   logic        rsp_out_last;

   binkp_command_arg_parser_unit i_dut (.*);

   // predictor state
   bcap_pkg::phase_type ph;
   logic [7:0]  cmd_q;
   logic [7:0]  esc_buf [3];
   int          esc_cnt;
   logic [31:0] acc [3];
   logic        got_digit;
   logic        err_q;

   parse_item_type parse_expected [$];
   int          failures;
   int          frames_sent;
   int          items_sent;
   int          names_checked;
   int          reports_checked;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_off_cycles;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
   endfunction

   function automatic logic [31:0] add_digit(logic [31:0] a, logic [7:0] c);
      logic [32:0] d;
      d = c - "0";
      if ({1'b0, a} > (33'hFFFF_FFFF - d) / 10) return 32'hFFFF_FFFF;
      return a * 10 + d[31:0];
   endfunction

   function automatic void clear_parse();
      ph = bcap_pkg::PH_CMD;
      cmd_q = 8'd0;
      esc_cnt = 0;
      for (int i = 0; i < 3; i++) begin
         acc[i] = 32'd0;
         esc_buf[i] = 8'd0;
      end
      got_digit = 1'b0;
      err_q = 1'b0;
   endfunction

   function automatic void push_name(logic [7:0] b);
      parse_item_type it;
      it = '{1'b0, b, 2'd0, cmd_q, 32'd0, 32'd0, 32'd0, 1'b0};
      parse_expected.push_back(it);
   endfunction

   // advance the parser by one byte and queue what it produces
   function automatic void predict_byte(logic [7:0] b, logic last);
      logic        file_cmd;
      logic        dig;
      logic [7:0]  buf4 [4];
      int          n;
      logic        bad;
      logic [1:0]  st;
      parse_item_type it;
      file_cmd = (cmd_q == bcap_pkg::CODE_FILE);
      dig = (b >= bcap_pkg::CHAR_D0 && b <= bcap_pkg::CHAR_D9);
      case (ph)
         bcap_pkg::PH_CMD: begin
            cmd_q = b;
            file_cmd = (b == bcap_pkg::CODE_FILE);
            if (b == bcap_pkg::CODE_FILE || b == bcap_pkg::CODE_GOT ||
                b == bcap_pkg::CODE_GET || b == bcap_pkg::CODE_SKIP)
               ph = bcap_pkg::PH_NAME;
            else
               ph = bcap_pkg::PH_OTHER;
         end
         bcap_pkg::PH_NAME: begin
            if (b == bcap_pkg::CHAR_SPACE) begin
               for (int i = 0; i < esc_cnt; i++) push_name(esc_buf[i]);
               esc_cnt = 0;
               got_digit = 1'b0;
               ph = bcap_pkg::PH_NUM1;
            end else if (b == bcap_pkg::CHAR_NUL) begin
               esc_cnt = 0;
               err_q = 1'b1;
               ph = bcap_pkg::PH_DRAIN;
            end else if (last) begin
               esc_cnt = 0;
            end else begin
               for (int i = 0; i < 3; i++) buf4[i] = esc_buf[i];
               buf4[3] = 8'd0;
               n = esc_cnt;
               buf4[n] = b;
               n++;
               while (n > 0) begin
                  if (buf4[0] != bcap_pkg::CHAR_BSL) bad = 1'b1;
                  else bad = (n >= 2 && buf4[1] != bcap_pkg::CHAR_X) ||
                             (n >= 3 && hex_digit(buf4[2]) < 0) ||
                             (n >= 4 && hex_digit(buf4[3]) < 0);
                  if (bad) begin
                     push_name(buf4[0]);
                     for (int i = 0; i < 3; i++) buf4[i] = buf4[i+1];
                     n--;
                  end else if (n == 4) begin
                     push_name(8'(hex_digit(buf4[2]) * 16 + hex_digit(buf4[3])));
                     n = 0;
                  end else begin
                     break;
                  end
               end
               for (int i = 0; i < 3; i++) esc_buf[i] = buf4[i];
               esc_cnt = n;
            end
         end
         bcap_pkg::PH_NUM1: begin
            if (dig) begin
               acc[0] = add_digit(acc[0], b);
               got_digit = 1'b1;
            end else if (file_cmd) begin
               if (b == bcap_pkg::CHAR_SPACE && got_digit) begin
                  got_digit = 1'b0;
                  ph = bcap_pkg::PH_NUM2;
               end else begin
                  err_q = 1'b1;
                  ph = bcap_pkg::PH_DRAIN;
               end
            end else begin
               ph = bcap_pkg::PH_DRAIN;
            end
         end
         bcap_pkg::PH_NUM2: begin
            if (dig) acc[1] = add_digit(acc[1], b);
            else if (b == bcap_pkg::CHAR_SPACE) ph = bcap_pkg::PH_NUM3;
            else if (b == bcap_pkg::CHAR_NUL) ph = bcap_pkg::PH_DRAIN;
            else begin
               err_q = 1'b1;
               ph = bcap_pkg::PH_DRAIN;
            end
         end
         bcap_pkg::PH_NUM3: begin
            if (dig) acc[2] = add_digit(acc[2], b);
            else ph = bcap_pkg::PH_DRAIN;
         end
         default: ;
      endcase
      if (last) begin
         if (ph == bcap_pkg::PH_OTHER) st = bcap_pkg::ST_NOT_PARSED;
         else if (ph == bcap_pkg::PH_NAME || err_q) st = bcap_pkg::ST_MALFORMED;
         else if (ph == bcap_pkg::PH_NUM1 && file_cmd) st = bcap_pkg::ST_MALFORMED;
         else st = bcap_pkg::ST_OK;
         it = '{1'b1, 8'd0, st, cmd_q, 32'd0, 32'd0, 32'd0, 1'b1};
         if (st == bcap_pkg::ST_OK) begin
            it.num0 = acc[0];
            if (file_cmd) begin
               it.num1 = acc[1];
               it.num2 = acc[2];
            end
         end
         parse_expected.push_back(it);
         clear_parse();
      end
   endfunction

   // send one item, idling at random beforehand
   task automatic send_byte(logic [7:0] b, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_byte(b, last);
      items_sent++;
      if (last) frames_sent++;
   endtask

   task automatic send_frame(logic [7:0] frame [$]);
      for (int i = 0; i < frame.size(); i++)
         send_byte(frame[i], i == frame.size() - 1);
   endtask

   function automatic void add_text(ref logic [7:0] f [$], input string s);
      for (int i = 0; i < s.len(); i++) f.push_back(s[i]);
   endfunction

   function automatic void add_number(ref logic [7:0] f [$]);
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(11, 14) : $urandom_range(0, 6);
      for (int i = 0; i < len; i++) f.push_back(8'($urandom_range("0", "9")));
   endfunction

   function automatic logic [7:0] hex_char();
      case ($urandom_range(2))
         0: return 8'($urandom_range("0", "9"));
         1: return 8'($urandom_range("A", "F"));
         default: return 8'($urandom_range("a", "f"));
      endcase
   endfunction

   // a random frame, mostly well formed
   function automatic void build_frame(ref logic [7:0] f [$]);
      logic [7:0] codes [4];
      int         len;
      codes = '{bcap_pkg::CODE_FILE, bcap_pkg::CODE_GOT, bcap_pkg::CODE_GET,
                bcap_pkg::CODE_SKIP};
      if ($urandom_range(9) == 0) begin
         // noise: any command byte, any content
         f.push_back(8'($urandom_range(255)));
         len = $urandom_range(0, 5);
         for (int i = 0; i < len; i++) f.push_back(8'($urandom_range(255)));
         return;
      end
      f.push_back(codes[$urandom_range(3)]);
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(5))
            0: begin
               f.push_back(bcap_pkg::CHAR_BSL);
               f.push_back(bcap_pkg::CHAR_X);
               f.push_back(hex_char());
               f.push_back(hex_char());
            end
            1: begin
               // broken escape
               f.push_back(bcap_pkg::CHAR_BSL);
               if ($urandom_range(1)) f.push_back(bcap_pkg::CHAR_X);
               if ($urandom_range(1)) f.push_back(8'($urandom_range(33, 255)));
            end
            2: f.push_back(8'($urandom_range(128, 255)));
            default: f.push_back(8'($urandom_range("a", "z")));
         endcase
      end
      if ($urandom_range(11) == 0) return;
      f.push_back(bcap_pkg::CHAR_SPACE);
      add_number(f);
      if ($urandom_range(7) == 0) f.push_back(8'($urandom_range(255)));
      f.push_back(bcap_pkg::CHAR_SPACE);
      add_number(f);
      if ($urandom_range(4) == 0) f.push_back(bcap_pkg::CHAR_NUL);
      else if ($urandom_range(7) == 0) f.push_back(8'($urandom_range(255)));
      else if ($urandom_range(1)) begin
         f.push_back(bcap_pkg::CHAR_SPACE);
         add_number(f);
         if ($urandom_range(3) == 0) f.push_back(8'($urandom_range(255)));
      end
   endfunction

   // receiver stall
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      parse_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (parse_expected.size() == 0) begin
            $error("result item with no expectation waiting");
            failures++;
         end else begin
            e = parse_expected.pop_front();
            if (rsp_out_kind !== e.kind) begin
               $error("out_kind exp %0h got %0h", e.kind, rsp_out_kind); failures++;
            end
            if (rsp_name_byte !== e.name_byte) begin
               $error("name_byte exp %0h got %0h", e.name_byte, rsp_name_byte);
               failures++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); failures++;
            end
            if (rsp_command_code !== e.cmd) begin
               $error("command_code exp %0h got %0h", e.cmd, rsp_command_code);
               failures++;
            end
            if (rsp_first_number !== e.num0) begin
               $error("first_number exp %0d got %0d", e.num0, rsp_first_number);
               failures++;
            end
            if (rsp_time_stamp !== e.num1) begin
               $error("time_stamp exp %0d got %0d", e.num1, rsp_time_stamp);
               failures++;
            end
            if (rsp_file_offset !== e.num2) begin
               $error("file_offset exp %0d got %0d", e.num2, rsp_file_offset);
               failures++;
            end
            if (rsp_out_last !== e.last) begin
               $error("out_last exp %0h got %0h", e.last, rsp_out_last); failures++;
            end
            if (e.kind) reports_checked++;
            else names_checked++;
         end
      end
   end

   function automatic void frame_of(ref logic [7:0] f [$], input logic [7:0] code,
                                    input string s);
      f = {};
      f.push_back(code);
      add_text(f, s);
   endfunction

   // directed frames: escapes, number edges, each command and error path
   task automatic test_directed();
      logic [7:0] f [$];
      frame_of(f, bcap_pkg::CODE_FILE, "a\\x4Fb\\xfe 123 4567 89");  send_frame(f);
      frame_of(f, bcap_pkg::CODE_FILE, "\\q\\x\\xg\\x4 99999999999 4294967296 7x");
      send_frame(f);
      frame_of(f, bcap_pkg::CODE_FILE, "n  5");                       send_frame(f);
      frame_of(f, bcap_pkg::CODE_FILE, "n 5 12a");                    send_frame(f);
      frame_of(f, bcap_pkg::CODE_FILE, "n 5 ");                       send_frame(f);
      frame_of(f, bcap_pkg::CODE_FILE, "n 5");                        send_frame(f);
      frame_of(f, bcap_pkg::CODE_GOT, "ab\\x");                       send_frame(f);
      frame_of(f, bcap_pkg::CODE_GET, "x 4294967295 rest");           send_frame(f);
      frame_of(f, bcap_pkg::CODE_SKIP, "x -3");                       send_frame(f);
      frame_of(f, bcap_pkg::CODE_GOT, "a\\x4");
      f.push_back(bcap_pkg::CHAR_NUL);
      add_text(f, " 9");
      send_frame(f);
      frame_of(f, bcap_pkg::CODE_FILE, "a 1 2");
      f.push_back(bcap_pkg::CHAR_NUL);
      add_text(f, "zz");
      send_frame(f);
      f = {}; f.push_back(bcap_pkg::CODE_FILE);                       send_frame(f);
      f = {}; f.push_back(bcap_pkg::CODE_SKIP);                       send_frame(f);
      f = {}; f.push_back(8'hFF); f.push_back(8'h00);                 send_frame(f);
      f = {}; f.push_back(8'h00); f.push_back(8'hFF);                 send_frame(f);
      frame_of(f, bcap_pkg::CODE_GET, "\\xFF\\x00\\xAa 0");           send_frame(f);
   endtask

   task automatic test_random(int frames);
      logic [7:0] f [$];
      repeat (frames) begin
         f = {};
         build_frame(f);
         send_frame(f);
      end
   endtask

   // receiver holds off while the sender keeps going
   task automatic test_backpressure();
      logic [7:0] f [$];
      hold_off_cycles <= 300;
      frame_of(f, bcap_pkg::CODE_FILE, "\\x41\\x42\\x43\\x44\\x45 11 22 33");
      send_frame(f);
      test_random(5);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (parse_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      failures = 0;
      frames_sent = 0;
      items_sent = 0;
      names_checked = 0;
      reports_checked = 0;
      hold_off_cycles = 0;
      send_idle_pct = 36;
      recv_idle_pct = 65;
      clear_parse();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'd0;
      req_in_last = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(5);
      test_backpressure();
      send_idle_pct = 65;
      recv_idle_pct = 36;
      test_random(5);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(5);
      wait_drained();
      $display("Sent %0d frames (%0d bytes); checked %0d name bytes and %0d reports.",
               frames_sent, items_sent, names_checked, reports_checked);
      $display("Covered escapes, saturation, error paths, idle mixes and a long hold-off.");
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
